// ===== src/binned_mean_and_inverse_sd_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binned mean / inverse sd core.
// ----------------------------------------------------------------------------
`ifndef BINNED_MEAN_AND_INVERSE_SD_CORE_DEFINES_SVH
`define BINNED_MEAN_AND_INVERSE_SD_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// property holds on every clock edge out of reset
`define BMISD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmisd: check failed");
// pre implies post in the next cycle
`define BMISD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bmisd: check failed");
`else
`define BMISD_ASSERT(lbl, prop)
`define BMISD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/bmisd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmisd_pkg
// Shared constants and types for the binned mean / inverse sd core.
// ----------------------------------------------------------------------------
package bmisd_pkg;

    localparam int NUM_BINS    = 256;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int SAMPLE_W    = 24;
    localparam int COUNT_W     = 16;
    localparam int SUM_W       = 40;
    localparam int SQ_W        = 64;
    localparam int SQR_W       = 2 * SAMPLE_W;
    localparam int ENTRY_W     = COUNT_W + SUM_W + SQ_W + 1;
    localparam int FRAC_SHIFT  = 40;
    localparam int PROD_W      = 80;
    localparam int ALU_W       = PROD_W + 2;
    localparam int ROOT_W      = PROD_W / 2;
    localparam int RECIP_W     = COUNT_W + FRAC_SHIFT;
    localparam int INV_W       = 32;

    // iteration counts of each sequencer phase
    localparam int DIV_STEPS   = SUM_W;
    localparam int MULA_STEPS  = COUNT_W;
    localparam int MULB_STEPS  = SUM_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int RECIP_STEPS = RECIP_W;
    localparam int CNT_W       = $clog2(RECIP_STEPS);

    // request actions
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_ADD_RD = 11'b000_0000_0010,
        S_ADD_WR = 11'b000_0000_0100,
        S_Q_RD   = 11'b000_0000_1000,
        S_Q_PREP = 11'b000_0001_0000,
        S_DIV    = 11'b000_0010_0000,
        S_MULA   = 11'b000_0100_0000,
        S_MULB   = 11'b000_1000_0000,
        S_SQRT   = 11'b001_0000_0000,
        S_RECIP  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } state_t;

endpackage
`default_nettype wire

// ===== src/bmisd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmisd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmisd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/binned_mean_and_inverse_sd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binned_mean_and_inverse_sd_core
// Per-bin count, sum and sum of squares with mean and 1/sd queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_ready) carry action, bin and sample. An add
//   request reads and then writes the bin and gives no result. A query request
//   gives one result on the output channel (out_valid/out_ready).
//   A query runs on one shared 82-bit add/subtract unit under a sequencer:
//   a read, a prepare step, 40 mean division steps, 16 + 40
//   multiply steps for n*sumsq - sum^2, 40 root steps and 56 reciprocal
//   steps, then a load of the output register. An empty bin goes from the
//   read straight to the finish state; a zero spread skips the reciprocal.
//   in_ready is high only while the sequencer is idle; one request at a time.
//   The result sits in an output register, so the next request is taken
//   while it waits; a following query holds in its last step until the
//   receiver takes the earlier result.
//   Reset clears the per-bin valid bits at once (empty bins read as zero),
//   sets lowest bin to 255, highest to 0 and clears the seen flag.
// ----------------------------------------------------------------------------
`include "binned_mean_and_inverse_sd_core_defines.svh"
module binned_mean_and_inverse_sd_core
    import bmisd_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       action,
    input  wire logic [BIN_W-1:0]           bin,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [BIN_W-1:0]                bin_out,
    output logic [1:0]                      status,
    output logic [COUNT_W-1:0]              sample_count,
    output logic signed [SAMPLE_W-1:0]      mean,
    output logic [INV_W-1:0]                inverse_sd,
    output logic [BIN_W-1:0]                lowest_bin,
    output logic [BIN_W-1:0]                highest_bin,
    output logic                            any_seen,
    output logic                            overflowed
);

    state_t                state_reg, state_next;

    // control
    logic [NUM_BINS-1:0]   valid_reg;
    logic [BIN_W-1:0]      lowest_reg, highest_reg;
    logic                  seen_reg;
    logic                  out_valid_reg;

    // request and add path
    logic [BIN_W-1:0]      bin_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SQR_W-1:0]      sq_add_reg;

    // query datapath
    logic [COUNT_W-1:0]    n_reg;
    logic                  neg_reg;
    logic [SUM_W-1:0]      mag_reg;
    logic [SQ_W-1:0]       sqs_reg;
    logic                  ovf_reg;
    logic [ALU_W-1:0]      work_reg;
    logic [PROD_W-1:0]     shf_reg;
    logic [PROD_W-1:0]     opd_reg;
    logic [RECIP_W-1:0]    res_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SAMPLE_W-1:0]   mean_reg;
    logic [1:0]            status_reg;
    logic [INV_W-1:0]      inv_reg;

    // output register
    logic [BIN_W-1:0]      bin_out_reg;
    logic [1:0]            status_out_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    logic [SAMPLE_W-1:0]   mean_out_reg;
    logic [INV_W-1:0]      inv_out_reg;
    logic [BIN_W-1:0]      lowest_out_reg, highest_out_reg;
    logic                  seen_out_reg, ovf_out_reg;

    // RAM
    logic                  ram_wr_en, ram_rd_en;
    logic [ENTRY_W-1:0]    ram_wr_data, ram_rd_data;

    // entry fields, empty when the bin was never written
    logic                  ent_valid;
    logic [COUNT_W-1:0]    ent_cnt;
    logic [SUM_W-1:0]      ent_sum;
    logic [SQ_W-1:0]       ent_sq;
    logic                  ent_ovf;
    logic                  ent_full;

    // shared unit
    logic [ALU_W-1:0]      alu_a, alu_b, alu_b_eff, alu_sum;
    logic                  alu_sub, alu_neg;

    logic                  in_accept, out_load, step_last;
    logic [SAMPLE_W-1:0]   smag;
    logic [SAMPLE_W-1:0]   mean_q;
    logic [ROOT_W-1:0]     root_val;
    logic [RECIP_W-1:0]    recip_q;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);
    assign step_last = (cnt_reg == '0);

    // bin store
    assign ram_rd_en = in_accept;
    assign ram_wr_en = (state_reg == S_ADD_WR);

    bmisd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (bin_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (bin),
        .rd_data (ram_rd_data)
    );

    assign ent_valid = valid_reg[bin_reg];
    assign ent_cnt   = ent_valid ? ram_rd_data[COUNT_W-1:0] : '0;
    assign ent_sum   = ent_valid ? ram_rd_data[COUNT_W +: SUM_W] : '0;
    assign ent_sq    = ent_valid ? ram_rd_data[COUNT_W+SUM_W +: SQ_W] : '0;
    assign ent_ovf   = ent_valid ? ram_rd_data[ENTRY_W-1] : 1'b0;
    assign ent_full  = (ent_cnt == '1);

    // add: a full bin only gets its overflow mark
    always_comb
    begin
        if (ent_full)
        begin
            ram_wr_data = {1'b1, ent_sq, ent_sum, ent_cnt};
        end
        else
        begin
            ram_wr_data = {ent_ovf,
                           ent_sq + SQ_W'(sq_add_reg),
                           ent_sum + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg},
                           ent_cnt + COUNT_W'(1)};
        end
    end

    assign smag = sample_reg[SAMPLE_W-1] ? (~sample_reg + SAMPLE_W'(1)) : sample_reg;

    // shared add/subtract unit: operands per phase
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_Q_PREP:
            begin
                alu_a = ALU_W'(mag_reg);
                alu_b = ALU_W'(n_reg >> 1);
            end
            S_DIV:
            begin
                alu_a   = {work_reg[ALU_W-2:0], shf_reg[PROD_W-1]};
                alu_b   = ALU_W'(n_reg);
                alu_sub = 1'b1;
            end
            S_MULA:
            begin
                alu_a = {work_reg[ALU_W-2:0], 1'b0};
                alu_b = shf_reg[PROD_W-1] ? ALU_W'(sqs_reg) : '0;
            end
            S_MULB:
            begin
                alu_a   = work_reg;
                alu_b   = shf_reg[0] ? ALU_W'(opd_reg) : '0;
                alu_sub = 1'b1;
            end
            S_SQRT:
            begin
                alu_a   = {work_reg[ALU_W-3:0], shf_reg[PROD_W-1 -: 2]};
                alu_b   = ALU_W'({res_reg[ROOT_W-1:0], 2'b01});
                alu_sub = 1'b1;
            end
            S_RECIP:
            begin
                alu_a   = {work_reg[ALU_W-2:0], shf_reg[PROD_W-1]};
                alu_b   = ALU_W'(opd_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
    assign alu_sum   = alu_a + alu_b_eff + ALU_W'(alu_sub);
    assign alu_neg   = alu_sum[ALU_W-1];

    // final quotient / root including the current step's bit
    assign mean_q   = {res_reg[SAMPLE_W-2:0], !alu_neg};
    assign root_val = {res_reg[ROOT_W-2:0], !alu_neg};
    assign recip_q  = {res_reg[RECIP_W-2:0], !alu_neg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACT_ADD) ? S_ADD_RD : S_Q_RD;
                end
            end
            S_ADD_RD: state_next = S_ADD_WR;
            S_ADD_WR: state_next = S_IDLE;
            S_Q_RD:   state_next = (ent_cnt == '0) ? S_FINISH : S_Q_PREP;
            S_Q_PREP: state_next = S_DIV;
            S_DIV:    state_next = step_last ? S_MULA : S_DIV;
            S_MULA:   state_next = step_last ? S_MULB : S_MULA;
            S_MULB:   state_next = step_last ? S_SQRT : S_MULB;
            S_SQRT:
            begin
                if (step_last)
                begin
                    state_next = (root_val == '0) ? S_FINISH : S_RECIP;
                end
            end
            S_RECIP:  state_next = step_last ? S_FINISH : S_RECIP;
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            lowest_reg    <= '1;
            highest_reg   <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // range tracking also counts dropped samples
            if (in_accept && (action == ACT_ADD))
            begin
                seen_reg <= 1'b1;
                if (bin < lowest_reg)
                begin
                    lowest_reg <= bin;
                end
                if (bin > highest_reg)
                begin
                    highest_reg <= bin;
                end
            end
            if (ram_wr_en)
            begin
                valid_reg[bin_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                bin_reg    <= bin;
                sample_reg <= sample;
            end
            S_ADD_RD:
            begin
                sq_add_reg <= smag * smag;
            end
            S_ADD_WR:
            begin
                sq_add_reg <= sq_add_reg;
            end
            S_Q_RD:
            begin
                n_reg   <= ent_cnt;
                neg_reg <= ent_sum[SUM_W-1];
                mag_reg <= ent_sum[SUM_W-1] ? (~ent_sum + SUM_W'(1)) : ent_sum;
                sqs_reg <= ent_sq;
                ovf_reg <= ent_ovf;
                if (ent_cnt == '0)
                begin
                    status_reg <= ST_EMPTY;
                    mean_reg   <= '0;
                    inv_reg    <= '0;
                end
            end
            S_Q_PREP:
            begin
                // rounded mean: (|sum| + n/2) / n
                shf_reg  <= {alu_sum[SUM_W-1:0], {(PROD_W-SUM_W){1'b0}}};
                work_reg <= '0;
                res_reg  <= '0;
                cnt_reg  <= CNT_W'(DIV_STEPS - 1);
            end
            S_DIV:
            begin
                work_reg <= alu_neg ? alu_a : alu_sum;
                res_reg  <= recip_q;
                shf_reg  <= {shf_reg[PROD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (step_last)
                begin
                    mean_reg <= neg_reg ? (~mean_q + SAMPLE_W'(1)) : mean_q;
                    shf_reg  <= {n_reg, {(PROD_W-COUNT_W){1'b0}}};
                    work_reg <= '0;
                    cnt_reg  <= CNT_W'(MULA_STEPS - 1);
                end
            end
            S_MULA:
            begin
                // n * sumsq, multiplier bits MSB first
                work_reg <= alu_sum;
                shf_reg  <= {shf_reg[PROD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (step_last)
                begin
                    shf_reg <= PROD_W'(mag_reg);
                    opd_reg <= PROD_W'(mag_reg);
                    cnt_reg <= CNT_W'(MULB_STEPS - 1);
                end
            end
            S_MULB:
            begin
                // subtract sum^2, multiplier bits LSB first
                work_reg <= alu_sum;
                shf_reg  <= {1'b0, shf_reg[PROD_W-1:1]};
                opd_reg  <= {opd_reg[PROD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (step_last)
                begin
                    // negative spread clamps to zero
                    shf_reg  <= alu_neg ? '0 : alu_sum[PROD_W-1:0];
                    work_reg <= '0;
                    res_reg  <= '0;
                    cnt_reg  <= CNT_W'(SQRT_STEPS - 1);
                end
            end
            S_SQRT:
            begin
                // two radicand bits per step
                work_reg <= alu_neg ? alu_a : alu_sum;
                res_reg  <= recip_q;
                shf_reg  <= {shf_reg[PROD_W-3:0], 2'b00};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (step_last)
                begin
                    opd_reg  <= PROD_W'(root_val);
                    shf_reg  <= {n_reg, {(PROD_W-COUNT_W){1'b0}}};
                    work_reg <= '0;
                    res_reg  <= '0;
                    cnt_reg  <= CNT_W'(RECIP_STEPS - 1);
                    if (root_val == '0)
                    begin
                        status_reg <= ST_SAT;
                        inv_reg    <= '1;
                    end
                end
            end
            S_RECIP:
            begin
                // (n << 40) / root
                work_reg <= alu_neg ? alu_a : alu_sum;
                res_reg  <= recip_q;
                shf_reg  <= {shf_reg[PROD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (step_last)
                begin
                    if (recip_q[RECIP_W-1:INV_W] != '0)
                    begin
                        status_reg <= ST_SAT;
                        inv_reg    <= '1;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        inv_reg    <= recip_q[INV_W-1:0];
                    end
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    bin_out_reg     <= bin_reg;
                    status_out_reg  <= status_reg;
                    count_out_reg   <= n_reg;
                    mean_out_reg    <= mean_reg;
                    inv_out_reg     <= inv_reg;
                    lowest_out_reg  <= lowest_reg;
                    highest_out_reg <= highest_reg;
                    seen_out_reg    <= seen_reg;
                    ovf_out_reg     <= ovf_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign bin_out      = bin_out_reg;
    assign status       = status_out_reg;
    assign sample_count = count_out_reg;
    assign mean         = mean_out_reg;
    assign inverse_sd   = inv_out_reg;
    assign lowest_bin   = lowest_out_reg;
    assign highest_bin  = highest_out_reg;
    assign any_seen     = seen_out_reg;
    assign overflowed   = ovf_out_reg;

    // checks
    `BMISD_ASSERT(a_bin_order, seen_reg |-> (lowest_reg <= highest_reg))
    `BMISD_ASSERT_NEXT(a_add_seq, in_accept && (action == ACT_ADD), state_reg == S_ADD_RD)
    `BMISD_ASSERT_NEXT(a_result_load, out_load, out_valid_reg && (state_reg == S_IDLE))

endmodule
`default_nettype wire
